### hdl/lpht_pkg.sv
package lpht_pkg;

    // request and key widths
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 11;

    // remainder unit: bits consumed per cycle
    localparam int MOD_STEPS = 4;
    localparam int MOD_ITERS = KEY_W / MOD_STEPS;
    localparam int MOD_CNT_W = $clog2(MOD_ITERS);

    // opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    // slot marks
    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2
    } t_mark;

endpackage

### hdl/lpht_mod.sv
module lpht_mod import lpht_pkg::*; #(
    parameter int DIV_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0]     r_dvd;
    logic [DIV_W-1:0]     r_div;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     n_rem;

    // restoring remainder, several dividend bits per cycle
    always_comb begin
        logic [DIV_W:0] t;
        n_rem = r_rem;
        for (int j = 0; j < MOD_STEPS; j++) begin
            t = {n_rem, r_dvd[KEY_W-1-j]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            n_rem = t[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == MOD_CNT_W'(MOD_ITERS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MOD_CNT_W'(MOD_ITERS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << MOD_STEPS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### hdl/linear_probe_hash_table_unit.sv
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_stall    i_opcode, i_key, i_data_in
// result    out        o_out_valid / i_out_stall  o_status, o_data_out, o_slot, o_probes
// config    in         i_cfg_we                   i_cfg_data (table_size)
//
// a remainder unit finds the home slot, then one slot is read per cycle;
// a request holds the block until its result is loaded into the output register
// (insert on a full count and unused opcodes skip the remainder unit and the probe loop)
// after reset a clearing pass over every slot empties the mark memory and stalls
// requests; config writes are taken as usual
// a result waits in the output register while the next request runs; that one then stalls
module linear_probe_hash_table_unit import lpht_pkg::*; #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config
    input  logic                     i_cfg_we,
    input  logic [CFG_W-1:0]         i_cfg_data,
    // request
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_opcode,
    input  logic [KEY_W-1:0]         i_key,
    input  logic signed [DATA_W-1:0] i_data_in,
    // result
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [2:0]               o_status,
    output logic signed [DATA_W-1:0] o_data_out,
    output logic [9:0]               o_slot,
    output logic [10:0]              o_probes
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CAP_W = IDX_W + 1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    // wrap-around successor of a slot index
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a,
                                                  input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] s;
        s = CAP_W'(a) + 1'b1;
        return (s >= c) ? '0 : s[IDX_W-1:0];
    endfunction

    // storage: marks are cleared after reset, keys and values are not
    t_mark                     mark_mem [MAX_SLOTS];
    logic [KEY_W+DATA_W-1:0]   kv_mem   [MAX_SLOTS];

    t_state                  r_state;
    logic [CFG_W-1:0]        r_table_size;
    logic [CAP_W-1:0]        r_count;
    logic [IDX_W-1:0]        r_clr_idx;

    // request held during processing
    logic [1:0]              r_op;
    logic [KEY_W-1:0]        r_key;
    logic [DATA_W-1:0]       r_data;

    // probe loop
    logic [IDX_W-1:0]        r_chk_idx;  // slot whose data is on the read port
    logic [IDX_W-1:0]        r_nxt_idx;  // slot being read speculatively
    logic [CAP_W-1:0]        r_reads;    // slots read before the current one
    logic                    r_has_free;
    logic [IDX_W-1:0]        r_free_idx;

    // memory read data
    t_mark                   r_mark_q;
    logic [KEY_W+DATA_W-1:0] r_kv_q;

    // staged result
    logic [2:0]              r_res_status;
    logic [DATA_W-1:0]       r_res_dout;
    logic [IDX_W-1:0]        r_res_slot;
    logic [CAP_W-1:0]        r_res_probes;

    // output register
    logic                    r_o_valid;
    logic [2:0]              r_o_status;
    logic [DATA_W-1:0]       r_o_dout;
    logic [9:0]              r_o_slot;
    logic [10:0]             r_o_probes;

    logic [CAP_W-1:0]        cap;
    logic                    in_xfer;
    logic                    out_xfer;
    logic                    out_load;
    logic                    mod_start;
    logic                    mod_done;
    logic [CAP_W-1:0]        mod_rem;
    logic [IDX_W-1:0]        home;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    mark_we;
    logic [IDX_W-1:0]        mark_waddr;
    t_mark                   mark_wdata;
    logic                    kv_we;
    logic [IDX_W-1:0]        kv_waddr;

    logic [CAP_W-1:0]        reads_now;
    logic                    hit;
    logic                    is_empty;
    logic                    free_now;
    logic [IDX_W-1:0]        free_idx_now;
    logic                    probe_end;
    logic [31:0]             slot_ext;
    logic [31:0]             probes_ext;

    // effective capacity: zero acts as one, clipped to the memory depth
    always_comb begin
        if (r_table_size == '0) begin
            cap = CAP_W'(1);
        end else if (32'(r_table_size) > 32'(MAX_SLOTS)) begin
            cap = CAP_W'(MAX_SLOTS);
        end else begin
            cap = CAP_W'(r_table_size);
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_o_valid && !i_out_stall;
    assign out_load   = (r_state == S_RESP) && (!r_o_valid || !i_out_stall);

    // home slot = key mod capacity, only for requests that probe
    assign mod_start = in_xfer && (i_opcode == OP_SEARCH || i_opcode == OP_REMOVE ||
                                   (i_opcode == OP_INSERT && r_count < cap));

    lpht_mod #(
        .DIV_W (CAP_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_key),
        .i_divisor  (cap),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign home = mod_rem[IDX_W-1:0];

    // decision on the slot whose data sits on the read port
    assign reads_now    = r_reads + 1'b1;
    assign hit          = (r_mark_q == MARK_USED) && (r_kv_q[KEY_W+DATA_W-1:DATA_W] == r_key);
    assign is_empty     = (r_mark_q == MARK_EMPTY);
    assign free_now     = r_has_free || (r_mark_q != MARK_USED);
    assign free_idx_now = r_has_free ? r_free_idx : r_chk_idx;
    assign probe_end    = hit || is_empty || (reads_now == cap);

    // read port: home slot first, then one speculative read per cycle
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_nxt_idx;
        if (r_state == S_HASH && mod_done) begin
            rd_en   = 1'b1;
            rd_addr = home;
        end else if (r_state == S_PROBE) begin
            rd_en   = 1'b1;
        end
    end

    // write ports, used by the clearing pass and at the end of a probe
    always_comb begin
        mark_we    = 1'b0;
        mark_waddr = r_chk_idx;
        mark_wdata = MARK_USED;
        kv_we      = 1'b0;
        kv_waddr   = r_chk_idx;
        if (r_state == S_CLEAR) begin
            mark_we    = 1'b1;
            mark_waddr = r_clr_idx;
            mark_wdata = MARK_EMPTY;
        end else if (r_state == S_PROBE && probe_end) begin
            case (r_op)
                OP_INSERT: begin
                    if (hit) begin
                        // update in place, key rewritten unchanged
                        kv_we = 1'b1;
                    end else if (free_now) begin
                        kv_we      = 1'b1;
                        kv_waddr   = free_idx_now;
                        mark_we    = 1'b1;
                        mark_waddr = free_idx_now;
                    end
                end
                OP_REMOVE: begin
                    if (hit) begin
                        mark_we    = 1'b1;
                        mark_wdata = MARK_DELETED;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (rd_en) begin
            r_mark_q <= mark_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (kv_we) begin
            kv_mem[kv_waddr] <= {r_key, r_data};
        end
        if (rd_en) begin
            r_kv_q <= kv_mem[rd_addr];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_table_size <= CFG_W'(10);
            r_count      <= '0;
            r_clr_idx    <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_data;
            end

            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (out_xfer) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IDX_W'(MAX_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (mod_start) begin
                        r_state <= S_HASH;
                    end else if (in_xfer) begin
                        // insert on a full count or unused opcode
                        r_state <= S_RESP;
                    end
                end
                S_HASH: begin
                    if (mod_done) begin
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (probe_end) begin
                        r_state <= S_RESP;
                        if (r_op == OP_INSERT && !hit && free_now) begin
                            r_count <= r_count + 1'b1;
                        end else if (r_op == OP_REMOVE && hit && r_count != '0) begin
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
                S_RESP: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= i_opcode;
            r_key  <= i_key;
            r_data <= i_data_in;
            // results of requests that skip the probe loop
            r_res_dout   <= '0;
            r_res_slot   <= '0;
            r_res_probes <= '0;
            r_res_status <= (i_opcode == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end

        if (r_state == S_HASH && mod_done) begin
            r_chk_idx  <= home;
            r_nxt_idx  <= wrap_inc(home, cap);
            r_reads    <= '0;
            r_has_free <= 1'b0;
        end else if (r_state == S_PROBE) begin
            r_chk_idx <= r_nxt_idx;
            r_nxt_idx <= wrap_inc(r_nxt_idx, cap);
            r_reads   <= reads_now;
            if (!r_has_free && r_mark_q != MARK_USED) begin
                r_has_free <= 1'b1;
                r_free_idx <= r_chk_idx;
            end
        end

        if (r_state == S_PROBE && probe_end) begin
            r_res_probes <= reads_now;
            case (r_op)
                OP_INSERT: begin
                    r_res_dout <= '0;
                    if (hit) begin
                        r_res_status <= ST_UPDATED;
                        r_res_slot   <= r_chk_idx;
                    end else if (free_now) begin
                        r_res_status <= ST_INSERTED;
                        r_res_slot   <= free_idx_now;
                    end else begin
                        r_res_status <= ST_FULL;
                        r_res_slot   <= '0;
                    end
                end
                OP_SEARCH: begin
                    if (hit) begin
                        r_res_status <= ST_FOUND;
                        r_res_dout   <= r_kv_q[DATA_W-1:0];
                        r_res_slot   <= r_chk_idx;
                    end else begin
                        r_res_status <= ST_NOT_FOUND;
                        r_res_dout   <= '0;
                        r_res_slot   <= '0;
                    end
                end
                OP_REMOVE: begin
                    r_res_dout <= '0;
                    if (hit) begin
                        r_res_status <= ST_REMOVED;
                        r_res_slot   <= r_chk_idx;
                    end else begin
                        r_res_status <= ST_NOT_FOUND;
                        r_res_slot   <= '0;
                    end
                end
                default: begin
                    r_res_status <= ST_NOT_FOUND;
                    r_res_dout   <= '0;
                    r_res_slot   <= '0;
                end
            endcase
        end
    end

    // fit the internal widths to the fixed result fields
    assign slot_ext   = 32'(r_res_slot);
    assign probes_ext = 32'(r_res_probes);

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_dout   <= r_res_dout;
            r_o_slot   <= slot_ext[9:0];
            r_o_probes <= probes_ext[10:0];
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_data_out  = r_o_dout;
    assign o_slot      = r_o_slot;
    assign o_probes    = r_o_probes;

endmodule

### test/tb_linear_probe_hash_table_unit.sv
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_unit import lpht_pkg::*; ();

    localparam int MAX_SLOTS = 1024;
    localparam logic [10:0] TABLE_SIZE_RESET = 11'd10;
    // opcode the block must answer as not found without touching the table
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one expected result, with the request that caused it for reporting
    typedef struct {
        logic [1:0]         req_op;
        logic [31:0]        req_key;
        logic [2:0]         status;
        logic signed [31:0] data_out;
        logic [9:0]         slot;
        logic [10:0]        probes;
    } t_table_result;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // config port
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    // request channel
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_opcode = OP_INSERT;
    logic [KEY_W-1:0]         i_key = '0;
    logic signed [DATA_W-1:0] i_data_in = '0;

    // result channel
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [2:0]               o_status;
    logic signed [DATA_W-1:0] o_data_out;
    logic [9:0]               o_slot;
    logic [10:0]              o_probes;

    // shadow copy of the table contents and the size register
    logic [10:0]  table_size_reg = TABLE_SIZE_RESET;
    logic [31:0]  key_mem [MAX_SLOTS];
    logic [31:0]  val_mem [MAX_SLOTS];
    t_mark        mark_mem [MAX_SLOTS] = '{default: MARK_EMPTY};
    int unsigned  live_count = 0;

    // results predicted but not yet seen on the result channel
    t_table_result expected_results[$];

    // run bookkeeping
    int  mismatch_count = 0;
    int  results_checked = 0;
    int  requests_sent = 0;
    int  size_writes = 0;
    int  status_tally [0:7] = '{default: 0};
    int  sink_hold_cycles = 0;
    // no random idling on either side once this is set
    bit  steady_traffic = 1'b0;

    linear_probe_hash_table_unit #(
        .MAX_SLOTS(MAX_SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_key       (i_key),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_slot      (o_slot),
        .o_probes    (o_probes)
    );

    always #4 i_clk = ~i_clk;

    // size 0 probes one slot, anything past the memory depth probes all of it
    function automatic int unsigned active_slots();
        if (table_size_reg == 0) return 1;
        if (table_size_reg > MAX_SLOTS) return MAX_SLOTS;
        return table_size_reg;
    endfunction

    // applies one request to the shadow table and returns what the block must answer
    function automatic t_table_result predict_request(input logic [1:0] op,
                                                      input logic [31:0] key,
                                                      input logic signed [31:0] data);
        t_table_result r;
        int unsigned cap, idx, n, free_idx;
        bit hit, has_free, stop;
        cap = active_slots();
        r.req_op = op;
        r.req_key = key;
        r.status = ST_NOT_FOUND;
        r.data_out = '0;
        r.slot = '0;
        r.probes = '0;
        hit = 1'b0;
        has_free = 1'b0;
        free_idx = 0;
        if (op == OP_INSERT && live_count >= cap) begin
            // count already at capacity: refused before any slot is read
            r.status = ST_FULL;
        end else if (op == OP_INSERT || op == OP_SEARCH || op == OP_REMOVE) begin
            // walk from the home slot until a match, an empty slot or a full lap;
            // tombstones keep the walk going but count as free for an insert
            idx = key % cap;
            n = 0;
            stop = 1'b0;
            while (n < cap && !stop) begin
                n++;
                if (mark_mem[idx] == MARK_USED && key_mem[idx] == key) begin
                    hit = 1'b1;
                    stop = 1'b1;
                end else begin
                    if (mark_mem[idx] != MARK_USED && !has_free) begin
                        has_free = 1'b1;
                        free_idx = idx;
                    end
                    if (mark_mem[idx] == MARK_EMPTY) stop = 1'b1;
                    else idx = (idx + 1 == cap) ? 0 : idx + 1;
                end
            end
            r.probes = n[10:0];
            if (op == OP_INSERT) begin
                if (hit) begin
                    val_mem[idx] = data;
                    r.status = ST_UPDATED;
                    r.slot = idx[9:0];
                end else if (has_free) begin
                    key_mem[free_idx] = key;
                    val_mem[free_idx] = data;
                    mark_mem[free_idx] = MARK_USED;
                    live_count++;
                    r.status = ST_INSERTED;
                    r.slot = free_idx[9:0];
                end else begin
                    r.status = ST_FULL;
                end
            end else if (hit && op == OP_SEARCH) begin
                r.status = ST_FOUND;
                r.data_out = val_mem[idx];
                r.slot = idx[9:0];
            end else if (hit) begin
                mark_mem[idx] = MARK_DELETED;
                if (live_count > 0) live_count--;
                r.status = ST_REMOVED;
                r.slot = idx[9:0];
            end
        end
        return r;
    endfunction

    // offers one request and holds it until the transfer; valid stays high after it
    task automatic send_request(input logic [1:0] op, input logic [31:0] key,
                                input logic signed [31:0] data);
        t_table_result want;
        i_opcode   <= op;
        i_key      <= key;
        i_data_in  <= data;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        // an unknown stall counts as stalled
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        want = predict_request(op, key, data);
        status_tally[want.status]++;
        expected_results.push_back(want);
        requests_sent++;
    endtask

    // random gap on the request side
    task automatic source_gap();
        if (!steady_traffic && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_table_size(input logic [10:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        table_size_reg = value;
        size_writes++;
        @(posedge i_clk);
    endtask

    // removes every live entry under the current size, so that a later size
    // change never strands an entry away from its home slot
    task automatic sweep_table();
        int unsigned cap;
        cap = active_slots();
        for (int unsigned s = 0; s < cap; s++) begin
            if (mark_mem[s] == MARK_USED) begin
                source_gap();
                send_request(OP_REMOVE, key_mem[s], $urandom);
            end
        end
        wait_all_results();
    endtask

    // every operation at the reset size of 10, with a collision chain
    task automatic test_default_size_ops();
        send_request(OP_INSERT, 32'd0, 32'sh7FFF_FFFF);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'sh8000_0000);
        send_request(OP_SEARCH, 32'hFFFF_FFFF, $urandom);
        send_request(OP_INSERT, 32'd0, -32'sd1);
        send_request(OP_SEARCH, 32'd0, $urandom);
        // 3, 13 and 23 share home slot 3; 23 lands past the key at slot 5, in slot 6
        send_request(OP_INSERT, 32'd3, $urandom);
        send_request(OP_INSERT, 32'd13, $urandom);
        send_request(OP_INSERT, 32'd23, $urandom);
        send_request(OP_REMOVE, 32'd13, $urandom);
        // the tombstone must not break the chain
        send_request(OP_SEARCH, 32'd23, $urandom);
        // update past the tombstone, no duplicate
        send_request(OP_INSERT, 32'd23, $urandom);
        // new key reuses the tombstone
        send_request(OP_INSERT, 32'd33, $urandom);
        send_request(OP_REMOVE, 32'd99, $urandom);
        send_request(OP_SEARCH, 32'd99, $urandom);
        send_request(OP_UNUSED, 32'd3, $urandom);
        send_request(OP_REMOVE, 32'd0, $urandom);
        send_request(OP_SEARCH, 32'd0, $urandom);
        sweep_table();
    endtask

    // count at capacity, laps with no empty slot, and size 0 acting as 1
    task automatic test_table_full();
        write_table_size(11'd4);
        for (int i = 0; i < 4; i++) send_request(OP_INSERT, 32'd100 + i, $urandom);
        // refused even though the key is present
        send_request(OP_INSERT, 32'd101, $urandom);
        send_request(OP_INSERT, 32'd500, $urandom);
        send_request(OP_SEARCH, 32'd777, $urandom);
        send_request(OP_REMOVE, 32'd102, $urandom);
        send_request(OP_SEARCH, 32'd777, $urandom);
        send_request(OP_INSERT, 32'd777, $urandom);
        sweep_table();
        write_table_size(11'd0);
        send_request(OP_INSERT, 32'd5, $urandom);
        send_request(OP_INSERT, 32'd6, $urandom);
        send_request(OP_SEARCH, 32'd5, $urandom);
        send_request(OP_REMOVE, 32'd5, $urandom);
        send_request(OP_INSERT, 32'd6, $urandom);
        wait_all_results();
        write_table_size(11'd1);
        send_request(OP_SEARCH, 32'd6, $urandom);
        sweep_table();
    endtask

    // sizes at and past the memory depth, wrap from the last slot to slot 0
    task automatic test_capacity_limits();
        write_table_size(11'd2047);
        send_request(OP_INSERT, 32'd1023, $urandom);
        send_request(OP_INSERT, 32'hFFFF_FFFF, $urandom);
        send_request(OP_SEARCH, 32'hFFFF_FFFF, $urandom);
        send_request(OP_REMOVE, 32'd1023, $urandom);
        send_request(OP_SEARCH, 32'hFFFF_FFFF, $urandom);
        sweep_table();
        write_table_size(11'd1024);
        send_request(OP_INSERT, 32'd2047, $urandom);
        send_request(OP_SEARCH, 32'd2047, $urandom);
        sweep_table();
        write_table_size(11'd1023);
        send_request(OP_INSERT, 32'hFFFF_FFFF, $urandom);
        send_request(OP_SEARCH, 32'hFFFF_FFFF, $urandom);
        sweep_table();
    endtask

    // shrinking keeps entries and count; slots past the new size are not probed
    task automatic test_capacity_shrink();
        write_table_size(11'd16);
        send_request(OP_INSERT, 32'd14, $urandom);
        send_request(OP_INSERT, 32'd15, $urandom);
        send_request(OP_INSERT, 32'd30, $urandom);
        wait_all_results();
        write_table_size(11'd8);
        send_request(OP_SEARCH, 32'd14, $urandom);
        send_request(OP_SEARCH, 32'd30, $urandom);
        wait_all_results();
        // three entries kept, so a size of 2 is already full
        write_table_size(11'd2);
        send_request(OP_INSERT, 32'd9, $urandom);
        wait_all_results();
        write_table_size(11'd16);
        send_request(OP_SEARCH, 32'd15, $urandom);
        send_request(OP_SEARCH, 32'd30, $urandom);
        sweep_table();
    endtask

    // long hold on the result side while requests keep coming, then a full pause
    task automatic test_output_backpressure();
        logic [31:0] k;
        write_table_size(11'd12);
        sink_hold_cycles = 200;
        for (int i = 0; i < 12; i++) begin
            // all share home slot 5
            k = (i % 8) * 12 + 5;
            send_request((i < 8) ? OP_INSERT : OP_SEARCH, k, $urandom);
        end
        wait_all_results();
        sweep_table();
    endtask

    // random mix over a pool of keys, half of them clustered around one home
    task automatic run_random_phase(input logic [10:0] size_value, input int n_items);
        logic [31:0] key_pool[$];
        int unsigned cap, anchor, pool_len, pick;
        logic [31:0] k;
        logic [1:0]  op;
        write_table_size(size_value);
        cap = active_slots();
        anchor = $urandom_range(0, cap - 1);
        pool_len = (cap > 32) ? 48 : cap + cap / 2 + 2;
        repeat (pool_len) begin
            k = $urandom;
            if ($urandom_range(0, 1) == 0) k = k - k % cap + (anchor + $urandom_range(0, 3)) % cap;
            key_pool.push_back(k);
        end
        repeat (n_items) begin
            source_gap();
            pick = $urandom_range(0, 99);
            if (pick < 45) op = OP_INSERT;
            else if (pick < 70) op = OP_SEARCH;
            else if (pick < 95) op = OP_REMOVE;
            else op = OP_UNUSED;
            if ($urandom_range(0, 6) == 0) k = $urandom;
            else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_request(op, k, $urandom);
        end
        sweep_table();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 12; p++) begin
            // last phase runs with no idling on either side
            if (p == 11) steady_traffic = 1'b1;
            // one phase at a large size, capped at the memory depth
            if (p == 5) run_random_phase(11'($urandom_range(900, 2047)), 60);
            run_random_phase(11'($urandom_range(1, 48)), 60);
        end
    endtask

    // result side pacing: random stall bursts, free stretches, and the long hold
    initial begin : result_pacing
        int run;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                run = sink_hold_cycles;
                sink_hold_cycles = 0;
                i_out_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!steady_traffic && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // every result transfer is compared with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_table_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%t: result with none expected: status %0d data %0d slot %0d probes %0d",
                             $time, o_status, o_data_out, o_slot, o_probes);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_status !== want.status || o_data_out !== want.data_out ||
                    o_slot !== want.slot || o_probes !== want.probes) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("%t: op %0d key %h: expected status %0d data %0d slot %0d ",
                               $time, want.req_op, want.req_key, want.status, want.data_out,
                               want.slot);
                        $display("probes %0d, got status %0d data %0d slot %0d probes %0d",
                                 want.probes, o_status, o_data_out, o_slot, o_probes);
                    end
                end
            end
        end
    end

    // watchdog, several times the slowest correct run including the clearing pass
    initial begin
        #50_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("linear_probe_hash_table_unit test failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the first request waits out the clearing pass through the stall
        test_default_size_ops();
        test_table_full();
        test_capacity_limits();
        test_capacity_shrink();
        test_output_backpressure();
        test_random_traffic();
        wait_all_results();
        repeat (20) @(posedge i_clk);
        $display("covered %0d requests over %0d table size writes, %0d results compared",
                 requests_sent, size_writes, results_checked);
        $display("outcomes: %0d inserted, %0d updated, %0d found, %0d not found, %0d removed, %0d full",
                 status_tally[ST_INSERTED], status_tally[ST_UPDATED], status_tally[ST_FOUND],
                 status_tally[ST_NOT_FOUND], status_tally[ST_REMOVED], status_tally[ST_FULL]);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("linear_probe_hash_table_unit test passed");
        else
            $display("linear_probe_hash_table_unit test failed");
        $finish;
    end

endmodule

### filelist.f
hdl/lpht_pkg.sv
hdl/lpht_mod.sv
hdl/linear_probe_hash_table_unit.sv
test/tb_linear_probe_hash_table_unit.sv
